/* rtl/gcl_pkg.sv */
`timescale 1ns / 1ps
// gcl_pkg: widths, item types and status struct for the GCD/LCM unit.
// No dependencies; imported by every module under rtl.

package gcl_pkg;

    // Operand bits that take part in the calculation
    localparam int OPERAND_WIDTH = 16;

    // Field widths of the items
    localparam int DW = 16;
    localparam int MW = 2 * DW;

    // Bits at and above OPERAND_WIDTH are ignored
    localparam logic [DW-1:0] OPERAND_MASK = (OPERAND_WIDTH >= DW) ? {DW{1'b1}} :
        DW'((32'd1 << OPERAND_WIDTH) - 32'd1);

    // Shift count for the common power of two in the GCD loop
    localparam int KW = $clog2(DW);

    // Bit counter of the serial divider and multiplier
    localparam int CW = $clog2(DW);

    typedef struct packed {
        logic [DW-1:0] first_value;
        logic [DW-1:0] second_value;
    } gcl_in_t;

    typedef struct packed {
        logic [DW-1:0] divisor;
        logic [MW-1:0] multiple;
        logic          operand_error;
    } gcl_out_t;

    // Status that each serial unit reports to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } gcl_stat_t;

endpackage

/* rtl/gcd_lcm_unit.sv */
`timescale 1ns / 1ps
// gcd_lcm_unit: greatest common divisor and least common multiple of two operands.
// Depends on gcl_pkg, gcl_gcd, gcl_div and gcl_mul.
//
// Usage:
//   s_valid/s_ready/s_data carry one operand pair per item; m_valid/m_ready/m_data
//   return one result item holding divisor, multiple and operand_error.
//   The divisor comes from a binary GCD loop (one step per cycle, at most 30
//   steps). The multiple is (first / divisor) * second, worked out by a
//   bit-serial restoring divider and then a shift-add multiplier.
//   An item with a zero operand skips the GCD loop and the serial units and
//   returns operand_error = 1 with the other fields 0. One item is worked on
//   at a time; s_ready is high whenever the sequencer is idle, also while an
//   earlier result waits in the output register, so a new item is taken only
//   once the previous result has been loaded into the output register.
//   If the receiver stalls, the finished result waits in the sequencer until
//   the output register frees up, and no new item is taken meanwhile.
//   Reset (aresetn low, synchronous) empties the output register and returns
//   the sequencer to idle.

module gcd_lcm_unit import gcl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  gcl_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output gcl_out_t m_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic          err_reg, err_next;
    logic          m_valid_reg, m_valid_next;
    gcl_out_t      out_reg, out_next;

    logic [DW-1:0] a_in;
    logic [DW-1:0] b_in;
    logic          in_zero;
    logic          accept;
    logic          load_out;
    logic          gcd_start, div_start, mul_start;
    gcl_stat_t     gcd_stat, div_stat, mul_stat;
    logic [DW-1:0] gcd_val;
    logic [DW-1:0] quot_val;
    logic [MW-1:0] prod_val;

    // Operand masking and zero check
    assign a_in    = s_data.first_value & OPERAND_MASK;
    assign b_in    = s_data.second_value & OPERAND_MASK;
    assign in_zero = (a_in == '0) || (b_in == '0);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Serial units
    gcl_gcd u_gcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (gcd_start),
        .a_in    (a_in),
        .b_in    (b_in),
        .stat    (gcd_stat),
        .gcd     (gcd_val)
    );

    gcl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (a_reg),
        .divisor  (gcd_val),
        .stat     (div_stat),
        .quotient (quot_val)
    );

    gcl_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (mul_start),
        .multiplier   (quot_val),
        .multiplicand (b_reg),
        .stat         (mul_stat),
        .product      (prod_val)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        err_next   = err_reg;
        gcd_start  = 1'b0;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    a_next   = a_in;
                    b_next   = b_in;
                    err_next = in_zero;
                    if (in_zero) begin
                        state_next = ST_DONE;
                    end else begin
                        gcd_start  = 1'b1;
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                if (gcd_stat.done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (load_out) begin
            out_next.divisor       = err_reg ? '0 : gcd_val;
            out_next.multiple      = err_reg ? '0 : prod_val;
            out_next.operand_error = err_reg;
            m_valid_next           = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        err_reg <= err_next;
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // An error result carries zero divisor and multiple
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.operand_error) |-> (m_data.divisor == '0 && m_data.multiple == '0))
        else $error("error result with non-zero fields");

    // A valid non-error result never holds a zero field
    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.operand_error) |-> (m_data.divisor != '0 && m_data.multiple != '0))
        else $error("zero field in non-error result");

    // A zero operand skips the serial units
    a_zero_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_zero) |=> (state_reg == ST_DONE && err_reg))
        else $error("zero operand not flagged");

    // GCD completion only while the sequencer waits for it
    a_gcd_done: assert property (@(posedge aclk) disable iff (!aresetn)
        gcd_stat.done |-> (state_reg == ST_GCD))
        else $error("GCD done outside its state");

    // Serial units are all quiet while the sequencer is idle
    a_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(gcd_stat.busy || div_stat.busy || mul_stat.busy))
        else $error("serial unit busy while idle");

endmodule

/* rtl/gcl_gcd.sv */
`timescale 1ns / 1ps
// gcl_gcd: binary GCD, one shift or subtract-and-shift step per cycle.
// Depends on gcl_pkg. Operands must be non-zero.

module gcl_gcd import gcl_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] a_in,
    input  logic [DW-1:0] b_in,
    output gcl_stat_t     stat,
    output logic [DW-1:0] gcd
);

    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [DW-1:0] g_reg, g_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW-1:0] diff_ab;
    logic [DW-1:0] diff_ba;

    assign diff_ab = a_reg - b_reg;
    assign diff_ba = b_reg - a_reg;

    // One reduction step; stop when both halves meet
    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a_in;
            b_next    = b_in;
            k_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (a_reg == b_reg) begin
                g_next    = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                case ({a_reg[0], b_reg[0]})
                    2'b00: begin
                        a_next = a_reg >> 1;
                        b_next = b_reg >> 1;
                        k_next = k_reg + KW'(1);
                    end
                    2'b01: a_next = a_reg >> 1;
                    2'b10: b_next = b_reg >> 1;
                    default: begin
                        if (a_reg > b_reg) begin
                            a_next = diff_ab >> 1;
                        end else begin
                            b_next = diff_ba >> 1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign gcd       = g_reg;

endmodule

/* rtl/gcl_div.sv */
`timescale 1ns / 1ps
// gcl_div: restoring divider, one quotient bit per cycle.
// Depends on gcl_pkg. Divisor must be non-zero.

module gcl_div import gcl_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output gcl_stat_t     stat,
    output logic [DW-1:0] quotient
);

    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] q_reg, q_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;

    // Partial remainder with the next dividend bit shifted in
    assign trial     = {rem_reg, q_reg[DW-1]};
    assign trial_sub = trial - {1'b0, d_reg};

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            q_next    = dividend;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial_sub[DW]) begin
                rem_next = trial_sub[DW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

/* rtl/gcl_mul.sv */
`timescale 1ns / 1ps
// gcl_mul: shift-add multiplier, one multiplier bit per cycle.
// Depends on gcl_pkg.

module gcl_mul import gcl_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] multiplier,
    input  logic [DW-1:0] multiplicand,
    output gcl_stat_t     stat,
    output logic [MW-1:0] product
);

    logic [DW-1:0] hi_reg, hi_next;
    logic [DW-1:0] lo_reg, lo_next;
    logic [DW-1:0] mc_reg, mc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   sum;

    // Add the multiplicand when the low bit is set, then shift right
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mc_reg} : {(DW + 1){1'b0}});

    always_comb begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        mc_next   = mc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            hi_next   = '0;
            lo_next   = multiplier;
            mc_next   = multiplicand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum[DW:1];
            lo_next  = {sum[0], lo_reg[DW-1:1]};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        mc_reg  <= mc_next;
        cnt_reg <= cnt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {hi_reg, lo_reg};

endmodule

/* tb/tb_gcd_lcm_unit.sv */
`timescale 1ns / 1ps
// tb_gcd_lcm_unit: self-checking bench for gcd_lcm_unit, directed pairs then random ones.
// Depends on gcl_pkg and the gcd_lcm_unit RTL; bursty sender, stalling receiver.

module tb_gcd_lcm_unit;
    import gcl_pkg::*;

    localparam int RANDOM_PAIRS   = 750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 150;

    // Receiver behaviour: open, coin-flip per stretch, or long stalls
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_CHOKED
    } rx_mode_e;

    // One operand pair waiting to go out; hold_back waits for the unit to drain first
    typedef struct {
        gcl_in_t operands;
        bit      hold_back;
    } operand_entry_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    gcl_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    gcl_out_t m_data;

    operand_entry_t operand_queue[$];
    gcl_out_t       gcd_lcm_due[$];

    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    int gap_left    = 0;
    int hold_left   = 0;
    int mode_left   = 0;
    rx_mode_e rx_mode = RX_OPEN;

    gcd_lcm_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Divisor by Euclid's remainders, multiple as (a / g) * b, zero operand flagged
    function automatic gcl_out_t gcd_lcm_of(gcl_in_t op);
        longint unsigned mask;
        longint unsigned a;
        longint unsigned b;
        longint unsigned x;
        longint unsigned y;
        longint unsigned r;
        longint unsigned prod;
        gcl_out_t res;
        mask = (OPERAND_WIDTH >= 64) ? ~64'd0 : ((64'd1 << OPERAND_WIDTH) - 64'd1);
        a = longint'(op.first_value) & mask;
        b = longint'(op.second_value) & mask;
        res = '0;
        if (a == 0 || b == 0) begin
            res.operand_error = 1'b1;
        end else begin
            x = a;
            y = b;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            prod = (a / x) * b;
            res.divisor  = x[DW-1:0];
            res.multiple = prod[MW-1:0];
        end
        return res;
    endfunction

    task automatic add_pair(input logic [DW-1:0] a, input logic [DW-1:0] b,
                            input bit hold_back);
        operand_entry_t entry;
        entry.operands.first_value  = a;
        entry.operands.second_value = b;
        entry.hold_back = hold_back;
        operand_queue.push_back(entry);
    endtask

    // Random pair, weighted towards shapes that stress the GCD loop
    task automatic add_random_pair(input bit hold_back);
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            // zero operand on either side or both
            a = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 65535);
            b = (a != 0 || $urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 65535);
        end else if (pick < 20) begin
            a = $urandom_range(1, 255);
            b = $urandom_range(1, 255);
        end else if (pick < 40) begin
            // small values shifted left by independent powers of two
            a = $urandom_range(1, 255) << $urandom_range(0, 8);
            b = $urandom_range(1, 255) << $urandom_range(0, 8);
        end else if (pick < 50) begin
            b = $urandom_range(1, 4096);
            a = b * $urandom_range(1, 65535 / b);
            if ($urandom_range(0, 1) == 1) begin
                pick = a;
                a = b;
                b = pick;
            end
        end else begin
            a = $urandom_range(0, 65535);
            b = $urandom_range(0, 65535);
        end
        add_pair(a[DW-1:0], b[DW-1:0], hold_back);
    endtask

    // Stimulus, then wait for everything to come back
    initial begin
        add_pair(16'd0, 16'd0, 1'b0);
        add_pair(16'd0, 16'd5, 1'b0);
        add_pair(16'd7, 16'd0, 1'b0);
        add_pair(16'd0, 16'hFFFF, 1'b0);
        add_pair(16'hFFFF, 16'd0, 1'b0);
        add_pair(16'd1, 16'd0, 1'b0);
        add_pair(16'd1, 16'd1, 1'b0);
        add_pair(16'd1, 16'hFFFF, 1'b0);
        add_pair(16'hFFFF, 16'd1, 1'b0);
        add_pair(16'hFFFF, 16'hFFFF, 1'b0);
        add_pair(16'hFFFF, 16'hFFFE, 1'b0);
        add_pair(16'd65521, 16'd65519, 1'b0);
        add_pair(16'h8000, 16'h8000, 1'b0);
        add_pair(16'h8000, 16'h4000, 1'b0);
        add_pair(16'd1024, 16'd768, 1'b0);
        add_pair(16'd40960, 16'd61440, 1'b0);
        add_pair(16'd12, 16'd18, 1'b0);
        add_pair(16'd48, 16'd180, 1'b0);
        add_pair(16'd2, 16'd3, 1'b0);
        add_pair(16'd17, 16'd17, 1'b0);
        add_pair(16'h5555, 16'hAAAA, 1'b0);

        // first random pair waits for the directed ones to drain
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            add_random_pair(i == 0 || $urandom_range(0, 99) == 0);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (operand_queue.size() > 0 || s_valid || gcd_lcm_due.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (gcd_lcm_due.size() != 0) begin
            $error("%0d results never arrived", gcd_lcm_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("gcd_lcm_unit verification clean");
        end else begin
            $display("gcd_lcm_unit verification failed");
        end
        $finish;
    end

    // Sender: bursts of items with gaps, predicts each item as it is accepted
    always @(posedge aclk) begin
        operand_entry_t entry;
        logic next_valid;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                gcd_lcm_due.push_back(gcd_lcm_of(s_data));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (operand_queue.size() > 0 &&
                             !(operand_queue[0].hold_back && gcd_lcm_due.size() > 0)) begin
                    entry = operand_queue.pop_front();
                    s_data <= entry.operands;
                    next_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        s_valid <= next_valid;
    end

    // Receiver: stall pattern switches between open, random and choked modes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(100, 400);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else begin
                case (rx_mode)
                    RX_OPEN: begin
                        m_ready <= 1'b1;
                        hold_left = 8;
                    end
                    RX_RANDOM: begin
                        m_ready <= 1'($urandom_range(0, 1));
                        hold_left = $urandom_range(0, 3);
                    end
                    default: begin
                        if (m_ready) begin
                            m_ready <= 1'b0;
                            hold_left = $urandom_range(1, 30);
                        end else begin
                            m_ready <= 1'b1;
                            hold_left = $urandom_range(0, 4);
                        end
                    end
                endcase
            end
        end
    end

    // Result check against the oldest prediction
    always @(posedge aclk) begin
        gcl_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (gcd_lcm_due.size() == 0) begin
                $error("unexpected result item: divisor %0d multiple %0d error %0b",
                       m_data.divisor, m_data.multiple, m_data.operand_error);
                fail_count++;
            end else begin
                want = gcd_lcm_due.pop_front();
                if (m_data.divisor !== want.divisor) begin
                    $error("divisor: expected %0d, got %0d", want.divisor, m_data.divisor);
                    fail_count++;
                end
                if (m_data.multiple !== want.multiple) begin
                    $error("multiple: expected %0d, got %0d", want.multiple, m_data.multiple);
                    fail_count++;
                end
                if (m_data.operand_error !== want.operand_error) begin
                    $error("operand_error: expected %0b, got %0b",
                           want.operand_error, m_data.operand_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("gcd_lcm_unit verification failed");
            $finish;
        end
    end

endmodule
